### rtl/core/spars_pkg.sv
// Shared constants, types and codes of the sparse point-add / range-sum block.
`timescale 1ns / 1ps

package spars_pkg;

  // Table depth and derived index and count widths.
  localparam int unsigned MAX_KEYS = 4096;
  localparam int unsigned IDX_W    = $clog2(MAX_KEYS);
  localparam int unsigned CNT_W    = $clog2(MAX_KEYS + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Request kinds.
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Flipping the sign bit makes unsigned order match signed order.
  localparam logic [31:0] KEY_BIAS = 32'h8000_0000;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_INVERTED = 2'd2
  } status_t;

  // Request from the controller to the entry store.
  typedef struct packed {
    logic        rd_en;
    idx_t        rd_addr;
    logic        wr_en;
    idx_t        wr_addr;
    logic [31:0] wr_key;
    logic [63:0] wr_val;
  } store_req_t;

  // Registered read data of the entry store.
  typedef struct packed {
    logic [31:0] key;
    logic [63:0] val;
  } store_rsp_t;

endpackage

### rtl/core/spars_if.sv
// Valid/ready channel interfaces for the request and result beats.
`timescale 1ns / 1ps

interface spars_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] coord;
  logic signed [31:0] amount;
  logic signed [31:0] upper;

  modport source (output valid, output req_type, output coord, output amount,
                  output upper, input ready);
  modport sink   (input valid, input req_type, input coord, input amount,
                  input upper, output ready);
endinterface

interface spars_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] range_sum;
  logic        [1:0]  status;

  modport source (output valid, output range_sum, output status, input ready);
  modport sink   (input valid, input range_sum, input status, output ready);
endinterface

### rtl/core/spars_store.sv
// Entry store: key and value memories with one read and one write port.
`timescale 1ns / 1ps

module spars_store import spars_pkg::*; (
  input  logic       clk,
  input  store_req_t req,
  output store_rsp_t rsp
);

  logic [31:0] key_mem [MAX_KEYS];
  logic [63:0] val_mem [MAX_KEYS];
  store_rsp_t  rsp_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      key_mem[req.wr_addr] <= req.wr_key;
      val_mem[req.wr_addr] <= req.wr_val;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rsp_r.key <= key_mem[req.rd_addr];
      rsp_r.val <= val_mem[req.rd_addr];
    end
  end

  assign rsp = rsp_r;

endmodule

### rtl/core/sparse_point_add_range_sum.sv
// Top level of the sparse point-add / range-sum block.
//
//   Channel  Direction  Beat contents
//   in_ch    sink       req_type, coord, amount, upper
//   out_ch   source     range_sum, status
//
// From acceptance until its result is loaded, an item sweeps the stored entries one
// per cycle through the single read port; an add that finds its coordinate stops
// the sweep at that entry, and an inverted query skips the sweep.
// Reset clears the entry count; the memories need no clearing pass.
// A result waits in the output register; the next beat is accepted while it
// waits, but that item's result is loaded only once the register is free.
`timescale 1ns / 1ps

module sparse_point_add_range_sum import spars_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  spars_in_if.sink    in_ch,
  spars_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic        kind_r, kind_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic [31:0] hi_r, hi_nxt;
  logic [63:0] amt_r, amt_nxt;
  cnt_t        cnt_r, cnt_nxt;
  cnt_t        rd_cnt_r, rd_cnt_nxt;
  logic        chk_vld_r, chk_vld_nxt;
  idx_t        chk_idx_r, chk_idx_nxt;
  logic [63:0] sum_r, sum_nxt;
  status_t     status_r, status_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic [63:0] out_sum_r, out_sum_nxt;
  status_t     out_status_r, out_status_nxt;

  store_req_t  st_req;
  store_rsp_t  st_rsp;

  logic        in_acc;
  logic        issue;
  logic        add_hit;
  logic        in_rng;
  logic        scan_end;
  logic        out_load;
  logic [31:0] in_lo;
  logic [31:0] in_hi;

  spars_store u_store (
    .clk (clk),
    .req (st_req),
    .rsp (st_rsp)
  );

  // Handshake and decoded request fields.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_lo       = in_ch.coord ^ KEY_BIAS;
  assign in_hi       = in_ch.upper ^ KEY_BIAS;

  // Scan control: one read issued per cycle, checked in the cycle after its issue.
  assign add_hit  = (state_r == S_SCAN) && chk_vld_r && (kind_r == REQ_ADD) &&
                    (st_rsp.key == lo_r);
  assign issue    = (state_r == S_SCAN) && (rd_cnt_r < cnt_r) && !add_hit;
  assign in_rng   = (st_rsp.key >= lo_r) && (st_rsp.key <= hi_r);
  assign scan_end = (state_r == S_SCAN) && !chk_vld_r && (rd_cnt_r == cnt_r);
  assign out_load = (state_r == S_DONE) && (!out_vld_r || out_ch.ready);

  // Store requests.
  always_comb begin
    st_req.rd_en   = issue;
    st_req.rd_addr = rd_cnt_r[IDX_W-1:0];
    st_req.wr_en   = 1'b0;
    st_req.wr_addr = chk_idx_r;
    st_req.wr_key  = lo_r;
    st_req.wr_val  = st_rsp.val + amt_r;
    if (add_hit) begin
      st_req.wr_en = 1'b1;
    end else if (scan_end && (kind_r == REQ_ADD) && (cnt_r < CNT_W'(MAX_KEYS))) begin
      st_req.wr_en   = 1'b1;
      st_req.wr_addr = cnt_r[IDX_W-1:0];
      st_req.wr_val  = amt_r;
    end
  end

  // Controller next state.
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    amt_nxt        = amt_r;
    cnt_nxt        = cnt_r;
    rd_cnt_nxt     = rd_cnt_r;
    chk_vld_nxt    = issue;
    chk_idx_nxt    = rd_cnt_r[IDX_W-1:0];
    sum_nxt        = sum_r;
    status_nxt     = status_r;
    out_vld_nxt    = out_vld_r && !out_ch.ready;
    out_sum_nxt    = out_sum_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt   = in_ch.req_type;
          lo_nxt     = in_lo;
          hi_nxt     = in_hi;
          amt_nxt    = {{32{in_ch.amount[31]}}, in_ch.amount};
          rd_cnt_nxt = '0;
          sum_nxt    = '0;
          status_nxt = STAT_OK;
          if ((in_ch.req_type == REQ_QUERY) && (in_lo > in_hi)) begin
            status_nxt = STAT_INVERTED;
            state_nxt  = S_DONE;
          end else begin
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        if (chk_vld_r && (kind_r == REQ_QUERY) && in_rng) begin
          sum_nxt = sum_r + st_rsp.val;
        end
        if (add_hit) begin
          state_nxt = S_DONE;
        end else if (scan_end) begin
          state_nxt = S_DONE;
          if (kind_r == REQ_ADD) begin
            if (cnt_r < CNT_W'(MAX_KEYS)) begin
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              status_nxt = STAT_FULL;
            end
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_vld_nxt    = 1'b1;
          out_sum_nxt    = sum_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    amt_r        <= amt_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    chk_idx_r    <= chk_idx_nxt;
    sum_r        <= sum_nxt;
    status_r     <= status_nxt;
    out_sum_r    <= out_sum_nxt;
    out_status_r <= out_status_nxt;
  end

  // Result beat.
  assign out_ch.valid     = out_vld_r;
  assign out_ch.range_sum = out_sum_r;
  assign out_ch.status    = out_status_r;

  // The entry count never passes the table depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_KEYS))
    else $error("entry count exceeds table depth");

  // The entry count only ever grows by one.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |-> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("entry count changed by more than one");

  // Memory writes happen only while an add is scanning.
  a_wr_add: assert property (@(posedge clk) disable iff (!rst_n)
    st_req.wr_en |-> ((state_r == S_SCAN) && (kind_r == REQ_ADD)))
    else $error("store write outside an add scan");

  // An accepted beat always leaves the idle state.
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("controller stayed idle after accepting a beat");

endmodule

### tb/sv/spars_checker.sv
// Scoreboard that predicts and checks every result beat of the range-sum block.
`timescale 1ns / 1ps

module spars_checker import spars_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  spars_in_if   in_mon,
  spars_out_if  out_mon,
  output int    error_count,
  output int    open_results
);

  typedef struct packed {
    logic [63:0] range_sum;
    status_t     status;
  } sum_result_t;

  // Shadow copy of the coordinate table and its accumulated totals.
  logic signed [31:0] coord_tab [MAX_KEYS];
  logic [63:0]        total_tab [MAX_KEYS];
  int                 used_entries = 0;

  sum_result_t expected_sums [$];
  int          errors = 0;

  // Apply one request to the shadow table and return the result it must give.
  function automatic sum_result_t tally_request(logic kind, logic signed [31:0] lo,
                                                logic signed [31:0] amt,
                                                logic signed [31:0] hi);
    sum_result_t res;
    bit          found;
    int          i;
    res.range_sum = '0;
    res.status    = STAT_OK;
    found         = 1'b0;
    if (kind == REQ_ADD) begin
      for (i = 0; i < used_entries && !found; i++) begin
        if (coord_tab[i] == lo) begin
          total_tab[i] = total_tab[i] + {{32{amt[31]}}, amt};
          found = 1'b1;
        end
      end
      // A new coordinate takes the next free entry, or is dropped when none is left.
      if (!found) begin
        if (used_entries < MAX_KEYS) begin
          coord_tab[used_entries] = lo;
          total_tab[used_entries] = {{32{amt[31]}}, amt};
          used_entries++;
        end else begin
          res.status = STAT_FULL;
        end
      end
    end else if (lo > hi) begin
      res.status = STAT_INVERTED;
    end else begin
      for (i = 0; i < used_entries; i++) begin
        if (coord_tab[i] >= lo && coord_tab[i] <= hi) begin
          res.range_sum = res.range_sum + total_tab[i];
        end
      end
    end
    return res;
  endfunction

  // Predict on every request beat, compare on every result beat.
  always @(posedge clk) begin
    sum_result_t want;
    if (!rst_n) begin
      used_entries = 0;
      expected_sums.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        expected_sums.insert(expected_sums.size(),
                             tally_request(in_mon.req_type, in_mon.coord,
                                           in_mon.amount, in_mon.upper));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got sum %0d status %0d",
                   $time, out_mon.range_sum, out_mon.status);
          errors++;
        end else begin
          want = expected_sums.pop_front();
          if (out_mon.range_sum !== want.range_sum) begin
            $display("%0t: range_sum mismatch, expected %0d, actual %0d",
                     $time, $signed(want.range_sum), out_mon.range_sum);
            errors++;
          end
          if (out_mon.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_mon.status);
            errors++;
          end
        end
      end
    end
    error_count  <= errors;
    open_results <= expected_sums.size();
  end

endmodule

### tb/sv/tb_sparse_point_add_range_sum.sv
// Top of the range-sum testbench: clock, reset, request stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module tb_sparse_point_add_range_sum import spars_pkg::*; ();

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 120;
  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int POOL_SIZE    = 24;

  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_CHOKE
  } rx_mode_t;

  logic clk;
  logic rst_n;
  int   error_count;
  int   open_results;
  int   idle_cycles = 0;
  int   burst_left  = 0;

  // Coordinates that recur often, so adds hit stored entries and ranges cover them.
  logic signed [31:0] hot_coords [POOL_SIZE];

  spars_in_if  in_ch ();
  spars_out_if out_ch ();

  sparse_point_add_range_sum uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  spars_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .error_count  (error_count),
    .open_results (open_results)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // Present one request beat, hold it until accepted, then maybe leave a gap.
  task automatic send_beat(logic kind, logic signed [31:0] lo, logic signed [31:0] amt,
                           logic signed [31:0] hi);
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= kind;
    in_ch.coord    <= lo;
    in_ch.amount   <= amt;
    in_ch.upper    <= hi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(30, 15) : $urandom_range(8, 1);
      gap = $urandom_range(6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Adds carry a random upper bound and queries a random amount; both are ignored.
  task automatic add_at(logic signed [31:0] where, logic signed [31:0] amt);
    send_beat(REQ_ADD, where, amt, $urandom());
  endtask

  task automatic ask_range(logic signed [31:0] lo, logic signed [31:0] hi);
    send_beat(REQ_QUERY, lo, $urandom(), hi);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
  endtask

  // Mostly recurring coordinates, some neighbors of them, some fresh ones.
  function automatic logic signed [31:0] pick_coord();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return hot_coords[$urandom_range(POOL_SIZE - 1)];
    if (roll < 75) return hot_coords[$urandom_range(POOL_SIZE - 1)] +
                          ($urandom_range(1) ? 32'sd1 : -32'sd1);
    return $urandom();
  endfunction

  function automatic logic signed [31:0] pick_amount();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) return COORD_MIN;
    if (roll == 1) return COORD_MAX;
    if (roll < 8) return $urandom_range(200) - 100;
    return $urandom();
  endfunction

  // The result side stalls on segments of its own: open, coin-flip, or mostly closed.
  initial begin
    rx_mode_t mode;
    int       seg_left;
    mode     = RX_OPEN;
    seg_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (seg_left == 0) begin
        mode     = rx_mode_t'($urandom_range(2));
        seg_left = $urandom_range(80, 20);
      end
      seg_left--;
      case (mode)
        RX_OPEN: begin
          out_ch.ready <= 1'b1;
        end
        RX_COIN: begin
          out_ch.ready <= 1'($urandom_range(1));
        end
        default: begin
          out_ch.ready <= ($urandom_range(7) == 0);
        end
      endcase
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Reset, directed requests, random requests, drain and verdict.
  initial begin
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] swap;
    int                 n;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= REQ_ADD;
    in_ch.coord    <= '0;
    in_ch.amount   <= '0;
    in_ch.upper    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    hot_coords[0] = COORD_MIN;
    hot_coords[1] = COORD_MAX;
    hot_coords[2] = 32'sd0;
    hot_coords[3] = -32'sd1;
    hot_coords[4] = 32'sd1;
    for (n = 5; n < POOL_SIZE; n++) begin
      hot_coords[n] = (n % 2 == 0) ? $urandom() : $urandom_range(2000) - 1000;
    end

    // Directed part: empty table, extreme coordinates and amounts, repeated
    // coordinates, single-point ranges, inverted ranges and empty ranges.
    ask_range(COORD_MIN, COORD_MAX);
    add_at(COORD_MIN, COORD_MAX);
    add_at(COORD_MAX, COORD_MIN);
    add_at(32'sd0, -32'sd1);
    add_at(32'sd0, 32'sd5);
    add_at(-32'sd1, 32'sh1234_5678);
    ask_range(COORD_MIN, COORD_MAX);
    ask_range(COORD_MIN, COORD_MIN);
    ask_range(COORD_MAX, COORD_MAX);
    ask_range(32'sd0, 32'sd0);
    ask_range(-32'sd1, 32'sd0);
    ask_range(COORD_MAX, COORD_MIN);
    ask_range(32'sd1, 32'sd0);
    ask_range(32'sd1, 32'sd1000);
    add_at(COORD_MIN, COORD_MIN);
    add_at(COORD_MIN, COORD_MIN);
    ask_range(COORD_MIN, -32'sd1);
    add_at(32'sd1000, 32'sd0);
    ask_range(32'sd2, COORD_MAX - 32'sd1);
    ask_range(COORD_MIN + 32'sd1, COORD_MAX);
    quiesce();

    // Random part, with one full pause in the middle.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) quiesce();
      if ($urandom_range(99) < 55) begin
        add_at(pick_coord(), pick_amount());
      end else begin
        lo = pick_coord();
        hi = pick_coord();
        // Most ranges are well ordered; a few stay inverted.
        if (lo > hi && $urandom_range(7) != 0) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
        if ($urandom_range(9) == 0) begin
          lo = COORD_MIN;
          hi = COORD_MAX;
        end
        ask_range(lo, hi);
      end
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && open_results == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
